// ===== src/spectrum_bar_smooth_peak_hold_defines.svh =====
// assertion macros for the spectrum bar smoothing and peak hold block
// used by the top level; expects clk and rst_n in the including scope
`ifndef SPECTRUM_BAR_SMOOTH_PEAK_HOLD_DEFINES_SVH
`define SPECTRUM_BAR_SMOOTH_PEAK_HOLD_DEFINES_SVH
`ifndef SYNTHESIS
`define SBSPH_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbsph assertion failed");
`define SBSPH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbsph assertion failed");
`else
`define SBSPH_ASSERT_IMPL(lbl, ante, cons)
`define SBSPH_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== src/sbsph_pkg.sv =====
// shared widths, defaults and register codes for the spectrum bar block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sbsph_pkg;

    localparam int BANDS_DEF      = 32;
    localparam int MAX_HEIGHT_DEF = 56;

    localparam int BAND_W  = 5;
    localparam int LEVEL_W = 8;
    localparam int MS_W    = 7;
    localparam int PX_W    = 6;
    localparam int LOW_W   = 5;
    localparam int MID_W   = 5;
    localparam int TOP_W   = 4;
    localparam int HGT_W   = 16;
    localparam int SPEED_W = 16;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 9;
    localparam int SMOOTH_W   = 9;
    localparam int GRAV_W     = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SMOOTHING = 8'd0,
        REG_GRAVITY   = 8'd1
    } cfg_reg_t;

    localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = 9'd90;
    localparam logic [SMOOTH_W-1:0] SMOOTH_ONE   = 9'd256;
    localparam logic [GRAV_W-1:0]   GRAV_RESET   = 8'd60;
    localparam logic [MS_W-1:0]     FRAME_MS_MAX = 7'd100;
    localparam logic [PX_W-1:0]     LOW_ZONE     = 6'd28;
    localparam logic [PX_W-1:0]     MID_ZONE     = 6'd45;
    localparam logic [HGT_W-1:0]    ONE_PX       = 16'd1024;

endpackage

`default_nettype wire

// ===== src/sbsph_if.sv =====
// item, result and configuration channels of the spectrum bar block
// depends on sbsph_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sbsph_item_if;
    import sbsph_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [BAND_W-1:0]    band;
    logic [LEVEL_W-1:0]   level;
    logic                 stale;
    logic [MS_W-1:0]      frame_ms;

    modport source (output valid, band, level, stale, frame_ms, input ready);
    modport sink   (input valid, band, level, stale, frame_ms, output ready);
endinterface

interface sbsph_result_if;
    import sbsph_pkg::*;
    logic               valid;
    logic               ready;
    logic [BAND_W-1:0]  band_out;
    logic [PX_W-1:0]    bar_px;
    logic [LOW_W-1:0]   low_len;
    logic [MID_W-1:0]   mid_len;
    logic [TOP_W-1:0]   top_len;
    logic [PX_W-1:0]    peak_px;
    logic               peak_shown;

    modport source (output valid, band_out, bar_px, low_len, mid_len, top_len, peak_px,
                    peak_shown, input ready);
    modport sink   (input valid, band_out, bar_px, low_len, mid_len, top_len, peak_px,
                    peak_shown, output ready);
endinterface

interface sbsph_cfg_if;
    import sbsph_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/sbsph_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sbsph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/spectrum_bar_smooth_peak_hold.sv =====
// top level of the spectrum bar smoothing and peak hold block
// depends on sbsph_pkg, sbsph_if, sbsph_ram and the defines header
// an accepted item passes the stage registers and the output register before result valid
// throughput: one item per cycle; an item whose band matches one of the five in the
// pipeline waits until that entry is written back to the state ram
// a held result stalls the whole pipeline
// reset: registers return to 90 and 60, band state reads as zero via per-band flags
`timescale 1ns / 1ps
`default_nettype none
`include "spectrum_bar_smooth_peak_hold_defines.svh"

module spectrum_bar_smooth_peak_hold #(
    parameter int BANDS         = sbsph_pkg::BANDS_DEF,
    parameter int MAX_HEIGHT_PX = sbsph_pkg::MAX_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    sbsph_cfg_if.sink         cfg,
    sbsph_item_if.sink        item,
    sbsph_result_if.source    result
);
    import sbsph_pkg::*;

    localparam int IDX_W   = $clog2(BANDS);
    localparam int ENTRY_W = 2 * HGT_W + SPEED_W;
    localparam int DIV_N   = 24;
    localparam int DIV_SH  = 32;
    localparam logic [24:0] DIV250_M  = 25'd17179870;
    localparam logic [DIV_N-1:0] RND_250 = 24'd125;

    typedef logic [IDX_W-1:0] idx_t;
    typedef idx_t idx_tab_t [2**BAND_W];
    typedef logic [HGT_W-1:0] tgt_tab_t [2**LEVEL_W];

    typedef struct packed {
        logic [HGT_W-1:0]   bar;
        logic [HGT_W-1:0]   peak;
        logic [SPEED_W-1:0] speed;
    } entry_t;

    typedef struct packed {
        logic [BAND_W-1:0] band;
        idx_t              idx;
        logic [MS_W-1:0]   ms;
        logic [HGT_W-1:0]  target;
        logic [14:0]       gm;
        logic              hit;
    } s1_t;

    typedef struct packed {
        logic [BAND_W-1:0] band;
        idx_t              idx;
        logic [MS_W-1:0]   ms;
        entry_t            ent;
        logic              up;
        logic [HGT_W-1:0]  step;
        logic [12:0]       inc;
    } s2_t;

    typedef struct packed {
        logic [BAND_W-1:0] band;
        idx_t              idx;
        logic [MS_W-1:0]   ms;
        entry_t            ent;
        logic              follow;
    } s3_t;

    typedef struct packed {
        logic [BAND_W-1:0] band;
        idx_t              idx;
        entry_t            ent;
        logic              follow;
        logic [22:0]       y;
    } s4_t;

    typedef struct packed {
        logic [BAND_W-1:0] band;
        idx_t              idx;
        entry_t            ent;
        logic              follow;
        logic [15:0]       drop;
    } s5_t;

    typedef struct packed {
        logic [BAND_W-1:0] band_out;
        logic [PX_W-1:0]   bar_px;
        logic [LOW_W-1:0]  low_len;
        logic [MID_W-1:0]  mid_len;
        logic [TOP_W-1:0]  top_len;
        logic [PX_W-1:0]   peak_px;
        logic              peak_shown;
    } res_t;

    function automatic idx_tab_t build_idx_tab();
        idx_tab_t t;
        for (int i = 0; i < 2**BAND_W; i++)
        begin
            t[i] = IDX_W'(i % BANDS);
        end
        return t;
    endfunction

    function automatic tgt_tab_t build_tgt_tab();
        tgt_tab_t t;
        longint   v;
        for (int i = 0; i < 2**LEVEL_W; i++)
        begin
            v = (longint'(i) * MAX_HEIGHT_PX * 1024 + 127) / 255;
            t[i] = (v > 65535) ? 16'hFFFF : 16'(v);
        end
        return t;
    endfunction

    // exact floor(n / 250) by reciprocal multiply for any n below 16384000, where the quotient fits 16 bits
    function automatic logic [15:0] div250(input logic [DIV_N-1:0] n);
        logic [48:0] p;
        p = 49'(n) * 49'(DIV250_M);
        return p[DIV_SH+15:DIV_SH];
    endfunction

    localparam idx_tab_t IDX_TAB = build_idx_tab();
    localparam tgt_tab_t TGT_TAB = build_tgt_tab();

    logic [SMOOTH_W-1:0] smooth_reg;
    logic [GRAV_W-1:0]   grav_reg;
    logic [BANDS-1:0]    valid_bits_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, out_vld_reg;
    s1_t  s1_reg;
    s2_t  s2_reg;
    s3_t  s3_reg;
    s4_t  s4_reg;
    s5_t  s5_reg;
    res_t out_reg;

    logic                adv;
    logic                hazard;
    logic                accept;
    idx_t                idx_in;
    logic [MS_W-1:0]     ms_sat;
    logic [SMOOTH_W-1:0] smooth_eff;

    logic [ENTRY_W-1:0]  ram_rdata;
    logic                ram_we;
    entry_t              wr_ent;

    entry_t              rd_ent;
    logic                st1_up;
    logic [HGT_W-1:0]    st1_diff;
    logic [24:0]         st1_prod;
    logic [15:0]         st1_q;

    logic [HGT_W-1:0]    st2_bar;
    logic [16:0]         st2_sum;
    logic [SPEED_W-1:0]  st2_speed;

    logic [HGT_W-1:0]    st5_peak;
    logic [PX_W-1:0]     st5_h;
    logic [PX_W-1:0]     st5_mid;
    logic [PX_W-1:0]     st5_top;
    res_t                st5_res;

    logic                wb_clash;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= SMOOTH_RESET;
            grav_reg   <= GRAV_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_SMOOTHING: smooth_reg <= cfg.data[SMOOTH_W-1:0];
                REG_GRAVITY:   grav_reg   <= cfg.data[GRAV_W-1:0];
                default:       ;
            endcase
        end
    end

    assign smooth_eff = (smooth_reg > SMOOTH_ONE) ? SMOOTH_ONE : smooth_reg;

    // input side and interlock
    assign adv    = !out_vld_reg || result.ready;
    assign idx_in = IDX_TAB[item.band];
    assign ms_sat = (item.frame_ms > FRAME_MS_MAX) ? FRAME_MS_MAX : item.frame_ms;
    assign hazard = (v1_reg && s1_reg.idx == idx_in) || (v2_reg && s2_reg.idx == idx_in)
                 || (v3_reg && s3_reg.idx == idx_in) || (v4_reg && s4_reg.idx == idx_in)
                 || (v5_reg && s5_reg.idx == idx_in);
    assign item.ready = adv && !hazard;
    assign accept     = item.valid && item.ready;

    sbsph_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BANDS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (s5_reg.idx),
        .wr_data (wr_ent),
        .rd_en   (accept),
        .rd_addr (idx_in),
        .rd_data (ram_rdata)
    );

    // stage 1: bar step product and speed increment
    always_comb
    begin
        rd_ent   = s1_reg.hit ? entry_t'(ram_rdata) : '0;
        st1_up   = s1_reg.target >= rd_ent.bar;
        st1_diff = st1_up ? (s1_reg.target - rd_ent.bar) : (rd_ent.bar - s1_reg.target);
        st1_prod = 25'(st1_diff) * 25'(smooth_eff);
        st1_q    = div250(24'({s1_reg.gm, 6'b0}) + RND_250);
    end

    // stage 2: new bar and accelerated speed
    always_comb
    begin
        st2_bar   = s2_reg.up ? (s2_reg.ent.bar + s2_reg.step)
                              : (s2_reg.ent.bar - s2_reg.step);
        st2_sum   = 17'(s2_reg.ent.speed) + 17'(s2_reg.inc);
        st2_speed = st2_sum[16] ? 16'hFFFF : st2_sum[15:0];
    end

    // stage 5: peak update, write back and zone split
    always_comb
    begin
        if (s5_reg.follow)
        begin
            st5_peak = s5_reg.ent.bar;
        end
        else if (s5_reg.drop >= s5_reg.ent.peak)
        begin
            st5_peak = '0;
        end
        else
        begin
            st5_peak = s5_reg.ent.peak - s5_reg.drop;
        end

        wr_ent.bar   = s5_reg.ent.bar;
        wr_ent.peak  = st5_peak;
        wr_ent.speed = s5_reg.follow ? '0 : s5_reg.ent.speed;

        st5_h   = s5_reg.ent.bar[HGT_W-1:HGT_W-PX_W];
        st5_mid = (st5_h > LOW_ZONE) ? (((st5_h < MID_ZONE) ? st5_h : MID_ZONE) - LOW_ZONE)
                                     : '0;
        st5_top = (st5_h > MID_ZONE) ? (st5_h - MID_ZONE) : '0;

        st5_res.band_out   = s5_reg.band;
        st5_res.bar_px     = st5_h;
        st5_res.low_len    = (st5_h < LOW_ZONE) ? st5_h[LOW_W-1:0] : LOW_ZONE[LOW_W-1:0];
        st5_res.mid_len    = st5_mid[MID_W-1:0];
        st5_res.top_len    = st5_top[TOP_W-1:0];
        st5_res.peak_px    = st5_peak[HGT_W-1:HGT_W-PX_W];
        st5_res.peak_shown = st5_peak > ONE_PX;
    end

    assign ram_we = v5_reg && adv;

    // pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            v4_reg         <= 1'b0;
            v5_reg         <= 1'b0;
            out_vld_reg    <= 1'b0;
            valid_bits_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                v1_reg      <= accept;
                v2_reg      <= v1_reg;
                v3_reg      <= v2_reg;
                v4_reg      <= v3_reg;
                v5_reg      <= v4_reg;
                out_vld_reg <= v5_reg;
            end
            if (ram_we)
            begin
                valid_bits_reg[s5_reg.idx] <= 1'b1;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg.band   <= item.band;
            s1_reg.idx    <= idx_in;
            s1_reg.ms     <= ms_sat;
            s1_reg.target <= item.stale ? '0 : TGT_TAB[item.level];
            s1_reg.gm     <= 15'(grav_reg) * 15'(ms_sat);
            s1_reg.hit    <= valid_bits_reg[idx_in];

            s2_reg.band <= s1_reg.band;
            s2_reg.idx  <= s1_reg.idx;
            s2_reg.ms   <= s1_reg.ms;
            s2_reg.ent  <= rd_ent;
            s2_reg.up   <= st1_up;
            s2_reg.step <= st1_prod[HGT_W+7:8];
            s2_reg.inc  <= st1_q[12:0];

            s3_reg.band       <= s2_reg.band;
            s3_reg.idx        <= s2_reg.idx;
            s3_reg.ms         <= s2_reg.ms;
            s3_reg.ent.bar    <= st2_bar;
            s3_reg.ent.peak   <= s2_reg.ent.peak;
            s3_reg.ent.speed  <= st2_speed;
            s3_reg.follow     <= st2_bar >= s2_reg.ent.peak;

            s4_reg.band   <= s3_reg.band;
            s4_reg.idx    <= s3_reg.idx;
            s4_reg.ent    <= s3_reg.ent;
            s4_reg.follow <= s3_reg.follow;
            s4_reg.y      <= 23'(s3_reg.ent.speed) * 23'(s3_reg.ms);

            s5_reg.band   <= s4_reg.band;
            s5_reg.idx    <= s4_reg.idx;
            s5_reg.ent    <= s4_reg.ent;
            s5_reg.follow <= s4_reg.follow;
            s5_reg.drop   <= div250(24'(s4_reg.y) + RND_250);

            out_reg <= st5_res;
        end
    end

    assign result.valid      = out_vld_reg;
    assign result.band_out   = out_reg.band_out;
    assign result.bar_px     = out_reg.bar_px;
    assign result.low_len    = out_reg.low_len;
    assign result.mid_len    = out_reg.mid_len;
    assign result.top_len    = out_reg.top_len;
    assign result.peak_px    = out_reg.peak_px;
    assign result.peak_shown = out_reg.peak_shown;

    // no two items of one band in flight at write back
    assign wb_clash = (v1_reg && s1_reg.idx == s5_reg.idx) || (v2_reg && s2_reg.idx == s5_reg.idx)
                   || (v3_reg && s3_reg.idx == s5_reg.idx) || (v4_reg && s4_reg.idx == s5_reg.idx);

    `SBSPH_ASSERT_IMPL(a_single_band_in_flight, v5_reg, !wb_clash)
    `SBSPH_ASSERT_NEXT(a_written_band_flagged, ram_we, valid_bits_reg[$past(s5_reg.idx)])
    `SBSPH_ASSERT_IMPL(a_result_from_last_stage, $rose(result.valid), $past(v5_reg && adv))

endmodule

`default_nettype wire

// ===== bench/spectrum_bar_smooth_peak_hold_test.sv =====
// self-checking testbench for spectrum_bar_smooth_peak_hold: directed table, then random
// bursts under random result stalls, every result checked against a per-band predictor
// or a typed table value; depends on sbsph_pkg, sbsph_if and the block's rtl
`timescale 1ns / 1ps

module spectrum_bar_smooth_peak_hold_test;
    import sbsph_pkg::*;

    typedef struct packed {
        logic [BAND_W-1:0]  band;
        logic [LEVEL_W-1:0] level;
        logic               stale;
        logic [MS_W-1:0]    frame_ms;
    } band_item_t;

    typedef struct packed {
        logic [BAND_W-1:0] band_out;
        logic [PX_W-1:0]   bar_px;
        logic [LOW_W-1:0]  low_len;
        logic [MID_W-1:0]  mid_len;
        logic [TOP_W-1:0]  top_len;
        logic [PX_W-1:0]   peak_px;
        logic              peak_shown;
    } bar_result_t;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_index;
        logic [CFG_DATA_W-1:0]  reg_data;
        logic [BAND_W-1:0]      band;
        logic [LEVEL_W-1:0]     level;
        logic                   stale;
        logic [MS_W-1:0]        frame_ms;
        logic                   typed;
        bar_result_t            want;
    } dir_row_t;

    // index outside the register list, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'hFF;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 250;
    localparam int DIR_ROWS = 28;

    localparam bar_result_t FULL_BAND2 = '{5'd2, 6'd56, 5'd28, 5'd17, 4'd11, 6'd56, 1'b1};
    localparam bar_result_t ZERO_BAND31 = '{5'd31, 6'd0, 5'd0, 5'd0, 4'd0, 6'd0, 1'b0};

    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd0, 8'd0, 1'b0, 7'd0, 1'b1, '0},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd31, 8'd255, 1'b1, 7'd127, 1'b1, ZERO_BAND31},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd1, 8'd255, 1'b0, 7'd10, 1'b0, '0},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd1, 8'd255, 1'b0, 7'd10, 1'b0, '0},
        '{ROW_CFG, REG_SMOOTHING, 9'd256, 5'd0, 8'd0, 1'b0, 7'd0, 1'b0, '0},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd2, 8'd255, 1'b0, 7'd0, 1'b1, FULL_BAND2},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd2, 8'd0, 1'b1, 7'd100, 1'b0, '0},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd2, 8'd255, 1'b1, 7'd127, 1'b0, '0},
        '{ROW_CFG, REG_GRAVITY, 9'd255, 5'd0, 8'd0, 1'b0, 7'd0, 1'b0, '0},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd2, 8'd0, 1'b1, 7'd100, 1'b0, '0},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd3, 8'd1, 1'b0, 7'd50, 1'b0, '0},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd4, 8'd128, 1'b0, 7'd20, 1'b0, '0},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd5, 8'd131, 1'b0, 7'd20, 1'b0, '0},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd6, 8'd206, 1'b0, 7'd20, 1'b0, '0},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd7, 8'd210, 1'b0, 7'd20, 1'b0, '0},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd8, 8'd10, 1'b0, 7'd100, 1'b0, '0},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd8, 8'd10, 1'b1, 7'd100, 1'b0, '0},
        '{ROW_CFG, REG_SMOOTHING, 9'd511, 5'd0, 8'd0, 1'b0, 7'd0, 1'b0, '0},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd9, 8'd200, 1'b0, 7'd33, 1'b0, '0},
        '{ROW_CFG, REG_SMOOTHING, 9'd0, 5'd0, 8'd0, 1'b0, 7'd0, 1'b0, '0},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd2, 8'd255, 1'b0, 7'd64, 1'b0, '0},
        '{ROW_CFG, REG_GRAVITY, 9'h1AA, 5'd0, 8'd0, 1'b0, 7'd0, 1'b0, '0},
        '{ROW_CFG, REG_NONE, 9'h155, 5'd0, 8'd0, 1'b0, 7'd0, 1'b0, '0},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd2, 8'd0, 1'b1, 7'd100, 1'b0, '0},
        '{ROW_CFG, REG_GRAVITY, 9'd0, 5'd0, 8'd0, 1'b0, 7'd0, 1'b0, '0},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd2, 8'd0, 1'b1, 7'd100, 1'b0, '0},
        '{ROW_CFG, REG_SMOOTHING, 9'd1, 5'd0, 8'd0, 1'b0, 7'd0, 1'b0, '0},
        '{ROW_ITEM, REG_NONE, 9'd0, 5'd10, 8'd255, 1'b0, 7'd1, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sbsph_cfg_if    cfg_ch ();
    sbsph_item_if   item_ch ();
    sbsph_result_if res_ch ();

    spectrum_bar_smooth_peak_hold DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (res_ch)
    );

    logic [SMOOTH_W-1:0] smooth_cfg = SMOOTH_RESET;
    logic [GRAV_W-1:0]   grav_cfg = GRAV_RESET;
    logic [HGT_W-1:0]    bar_height [BANDS_DEF] = '{default: '0};
    logic [HGT_W-1:0]    peak_height [BANDS_DEF] = '{default: '0};
    logic [SPEED_W-1:0]  fall_rate [BANDS_DEF] = '{default: '0};

    bar_result_t pending_bars [$];
    int mismatches = 0;
    int ready_mode = 0;
    int ready_left = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int unsigned clamp16(int unsigned v);
        return v > 32'hFFFF ? 32'hFFFF : v;
    endfunction

    function automatic bar_result_t advance_band(band_item_t it);
        int unsigned idx, s, ms, lvl, target, bar, peak, speed, drop, h;
        bar_result_t r;
        idx = it.band % BANDS_DEF;
        s = smooth_cfg > SMOOTH_ONE ? SMOOTH_ONE : smooth_cfg;
        ms = it.frame_ms > FRAME_MS_MAX ? FRAME_MS_MAX : it.frame_ms;
        lvl = it.level;
        target = 0;
        if (!it.stale)
            target = clamp16((lvl * MAX_HEIGHT_DEF * 1024 + 127) / 255);
        bar = bar_height[idx];
        if (target >= bar)
            bar = bar + (((target - bar) * s) >> 8);
        else
            bar = bar - (((bar - target) * s) >> 8);
        peak = peak_height[idx];
        speed = fall_rate[idx];
        if (bar >= peak)
        begin
            peak = bar;
            speed = 0;
        end
        else
        begin
            speed = clamp16(speed + (grav_cfg * ms * 256 + 500) / 1000);
            drop = (speed * ms * 4 + 500) / 1000;
            peak = drop >= peak ? 0 : peak - drop;
        end
        bar_height[idx] = bar[HGT_W-1:0];
        peak_height[idx] = peak[HGT_W-1:0];
        fall_rate[idx] = speed[SPEED_W-1:0];
        h = bar >> 10;
        r.band_out = it.band;
        r.bar_px = h[PX_W-1:0];
        r.low_len = h < LOW_ZONE ? h[LOW_W-1:0] : LOW_ZONE[LOW_W-1:0];
        r.mid_len = MID_W'(h > LOW_ZONE ? ((h < MID_ZONE ? h : MID_ZONE) - LOW_ZONE) : 0);
        r.top_len = TOP_W'(h > MID_ZONE ? h - MID_ZONE : 0);
        r.peak_px = peak[PX_W+9:10];
        r.peak_shown = peak > ONE_PX;
        return r;
    endfunction

    function automatic band_item_t random_band_item();
        band_item_t it;
        int pick;
        it.band = $urandom_range(0, 1) ? BAND_W'($urandom_range(0, 3))
                                       : BAND_W'($urandom_range(0, 31));
        pick = $urandom_range(0, 9);
        it.level = pick == 0 ? 8'd0 : pick == 1 ? 8'd255 : LEVEL_W'($urandom_range(0, 255));
        it.stale = $urandom_range(0, 5) == 0;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            it.frame_ms = '0;
        else if (pick < 3)
            it.frame_ms = MS_W'($urandom_range(101, 127));
        else
            it.frame_ms = MS_W'($urandom_range(1, 100));
        return it;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_band(band_item_t it, logic typed, bar_result_t want);
        bar_result_t predicted;
        item_ch.valid = 1'b1;
        item_ch.band = it.band;
        item_ch.level = it.level;
        item_ch.stale = it.stale;
        item_ch.frame_ms = it.frame_ms;
        do
            @(posedge clk);
        while (!item_ch.ready);
        predicted = advance_band(it);
        pending_bars.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        case (idx)
            REG_SMOOTHING: smooth_cfg = val[SMOOTH_W-1:0];
            REG_GRAVITY:   grav_cfg = val[GRAV_W-1:0];
            default:       ;
        endcase
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        item_ch.valid = 1'b0;
        while (pending_bars.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // result stalls: always ready, random, or a regular pattern, each for a random stretch
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(10, 80);
        end
        else
            ready_left--;
        case (ready_mode)
            0:       res_ch.ready = 1'b1;
            1:       res_ch.ready = $urandom_range(0, 1);
            default: res_ch.ready = (ready_left % 4) != 0;
        endcase
    end

    always @(posedge clk)
    begin
        bar_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_bars.size() == 0)
            begin
                $error("result for band %0d with no transfer pending", res_ch.band_out);
                mismatches++;
            end
            else
            begin
                want = pending_bars.pop_front();
                check_field("band_out", want.band_out, res_ch.band_out);
                check_field("bar_px", want.bar_px, res_ch.bar_px);
                check_field("low_len", want.low_len, res_ch.low_len);
                check_field("mid_len", want.mid_len, res_ch.mid_len);
                check_field("top_len", want.top_len, res_ch.top_len);
                check_field("peak_px", want.peak_px, res_ch.peak_px);
                check_field("peak_shown", want.peak_shown, res_ch.peak_shown);
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        dir_row_t row;
        band_item_t it;
        int left, burst, gap;
        item_ch.valid = 1'b0;
        item_ch.band = '0;
        item_ch.level = '0;
        item_ch.stale = 1'b0;
        item_ch.frame_ms = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        res_ch.ready = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_CFG)
            begin
                wait_drained();
                write_reg(row.reg_index, row.reg_data);
            end
            else
            begin
                it = '{row.band, row.level, row.stale, row.frame_ms};
                send_band(it, row.typed, row.want);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0:
                begin
                    write_reg(REG_SMOOTHING, 9'd256);
                    write_reg(REG_GRAVITY, 9'd255);
                end
                1:
                begin
                    write_reg(REG_SMOOTHING, 9'd511);
                    write_reg(REG_GRAVITY, 9'd0);
                end
                2:
                begin
                    write_reg(REG_SMOOTHING, 9'd1);
                    write_reg(REG_GRAVITY, 9'd128);
                end
                default:
                begin
                    write_reg(REG_SMOOTHING, CFG_DATA_W'($urandom_range(16, 300)));
                    write_reg(REG_GRAVITY, CFG_DATA_W'($urandom_range(0, 255)));
                end
            endcase
            left = PHASE_ITEMS;
            while (left > 0)
            begin
                burst = $urandom_range(1, 20);
                for (int k = 0; k < burst && left > 0; k++)
                begin
                    send_band(random_band_item(), 1'b0, '0);
                    left--;
                end
                item_ch.valid = 1'b0;
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                repeat (gap) @(negedge clk);
            end
        end

        wait_drained();
        repeat (12) @(posedge clk);
        if (mismatches == 0 && pending_bars.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/sbsph_pkg.sv
src/sbsph_if.sv
src/sbsph_ram.sv
src/spectrum_bar_smooth_peak_hold.sv
bench/spectrum_bar_smooth_peak_hold_test.sv
